// ===== design/htd_pkg.sv =====
package htd_pkg;

    // Tree capacity
    localparam int MAX_LEAVES = 256;
    localparam int NODE_CAP   = 2 * MAX_LEAVES - 1;
    localparam int IDX_W      = $clog2(NODE_CAP);
    localparam int NODE_DEPTH = 2 ** IDX_W;
    localparam int STACK_AW   = $clog2(MAX_LEAVES);
    localparam int DEPTH_W    = STACK_AW + 1;
    localparam int USED_W     = IDX_W + 1;

    // Field widths
    localparam int SYM_W  = 8;
    localparam int CNT_W  = 31;
    localparam int TREE_W = 9;
    localparam int BIT_W  = 3;
    localparam int PEND_W = 4;

    // APB port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Symbol-bit countdown codes
    localparam logic [PEND_W-1:0] PEND_TAG  = 4'd0;
    localparam logic [PEND_W-1:0] PEND_LAST = 4'd1;
    localparam logic [PEND_W-1:0] PEND_FULL = 4'd8;
    localparam logic [PEND_W-1:0] PEND_DONE = 4'd15;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_node;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_node            data;
    } t_node_wr;

    typedef enum logic [0:0] {
        REG_OUTPUT_LENGTH = 1'b0,
        REG_TREE_BYTES    = 1'b1
    } t_reg;

endpackage

// ===== design/huffman_tree_rebuild_and_decode_core.sv =====
// Huffman tree rebuild and decode. Bytes arrive on the input channel and are
// consumed MSB first; per bit, S_RD reads the build stack (header) or the node
// table (payload) and S_EX acts on the registered read data in the next cycle.
// The first tree_bytes bytes rebuild the code tree from its post-order form
// (1 + 8 symbol bits = leaf, 0 = join the top two nodes); after the tree is
// closed the rest of the header is padding. Later bytes walk the tree, 0 left
// and 1 right, and each leaf gives one symbol beat until output_length symbols
// have been sent. A byte is accepted in S_IDLE, each bit then passes S_RD and
// S_EX, and a payload byte ends in S_FLUSH; output stalls can hold S_EX and
// S_FLUSH. A payload byte with no tree built returns at once. Each symbol is
// held one step so that the last one of a byte can be marked run_last; the
// block takes the next byte while that beat waits in the output register.
// Node table (512 x 27) and build stack (256 x 9) need no clearing: only written
// entries are ever reached. Registers sit at byte address 0 (output_length) and
// 4 (tree_bytes); the user must write them only while idle (not enforced).
module huffman_tree_rebuild_and_decode_core import htd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [SYM_W-1:0]  i_stream_byte,
    // symbol output
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SYM_W-1:0]  o_symbol,
    output logic              o_run_last,
    output logic              o_stream_done,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_EX    = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_byte, n_byte;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_payload, n_payload;
    logic [TREE_W-1:0]  r_hdr_seen, n_hdr_seen;
    logic [CNT_W-1:0]   r_emitted, n_emitted;
    logic [CNT_W-1:0]   r_out_len, n_out_len;
    logic [TREE_W-1:0]  r_tree_bytes, n_tree_bytes;
    // one-deep hold so the last symbol of a byte can be tagged
    logic               r_hold_valid, n_hold_valid;
    logic [SYM_W-1:0]   r_hold_sym, n_hold_sym;
    logic               r_hold_done, n_hold_done;
    // output register
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_out_sym, n_out_sym;
    logic               r_out_last, n_out_last;
    logic               r_out_done, n_out_done;

    logic               w_in_acc;
    logic               w_out_take;
    logic               w_out_free;
    logic               w_cfg_wr;
    t_reg               w_reg;
    logic               w_reached;
    logic [CNT_W-1:0]   w_emit_next;
    logic               w_done;
    logic               w_hit;
    logic [SYM_W-1:0]   w_hit_sym;
    logic               w_emit;
    logic               w_adv;
    logic               w_depth_nz;
    t_node_wr           w_node_wr;

    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_take  = r_out_valid && !i_stall;
    assign w_out_free  = !r_out_valid || w_out_take;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign w_reg       = t_reg'(paddr[2]);
    assign w_reached   = r_emitted >= r_out_len;
    assign w_emit_next = r_emitted + CNT_W'(1);
    assign w_done      = w_emit_next == r_out_len;
    assign w_emit      = (r_state == S_EX) && r_payload && !w_reached && w_hit;
    // a new symbol can enter the hold only if the held one can move out
    assign w_adv       = !w_emit || !r_hold_valid || w_out_free;

    htd_tree_build u_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       ((r_state == S_RD) && !r_payload),
        .i_step     ((r_state == S_EX) && !r_payload),
        .i_bit      (r_byte[SYM_W-1]),
        .o_node_wr  (w_node_wr),
        .o_depth_nz (w_depth_nz)
    );

    htd_tree_walk u_walk (
        .i_clk     (i_clk),
        .i_node_wr (w_node_wr),
        .i_rd      ((r_state == S_RD) && r_payload),
        .i_bit     (r_byte[SYM_W-1]),
        .i_commit  ((r_state == S_EX) && r_payload && !w_reached && w_adv),
        .o_hit     (w_hit),
        .o_hit_sym (w_hit_sym)
    );

    always_comb begin
        n_state      = r_state;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_payload    = r_payload;
        n_hdr_seen   = r_hdr_seen;
        n_emitted    = r_emitted;
        n_out_len    = r_out_len;
        n_tree_bytes = r_tree_bytes;
        n_hold_valid = r_hold_valid;
        n_hold_sym   = r_hold_sym;
        n_hold_done  = r_hold_done;
        n_out_valid  = r_out_valid;
        n_out_sym    = r_out_sym;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        if (w_cfg_wr) begin
            unique case (w_reg)
                REG_OUTPUT_LENGTH: n_out_len    = pwdata[CNT_W-1:0];
                REG_TREE_BYTES:    n_tree_bytes = pwdata[TREE_W-1:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_byte = i_stream_byte;
                    n_bit  = '0;
                    if (r_hdr_seen < r_tree_bytes) begin
                        n_payload  = 1'b0;
                        n_hdr_seen = r_hdr_seen + TREE_W'(1);
                        n_state    = S_RD;
                    end else if (w_depth_nz) begin
                        n_payload = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (w_adv) begin
                    if (w_emit) begin
                        n_emitted = w_emit_next;
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_sym   = r_hold_sym;
                            n_out_last  = 1'b0;
                            n_out_done  = r_hold_done;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_sym   = w_hit_sym;
                        n_hold_done  = w_done;
                    end
                    n_byte = {r_byte[SYM_W-2:0], 1'b0};
                    n_bit  = r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(SYM_W - 1)) begin
                        n_state = r_payload ? S_FLUSH : S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_FLUSH: begin
                // held symbol is the last one of this byte
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_hold_sym;
                    n_out_last   = 1'b1;
                    n_out_done   = r_hold_done;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bit        <= '0;
            r_payload    <= 1'b0;
            r_hdr_seen   <= '0;
            r_emitted    <= '0;
            r_out_len    <= '0;
            r_tree_bytes <= TREE_W'(1);
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bit        <= n_bit;
            r_payload    <= n_payload;
            r_hdr_seen   <= n_hdr_seen;
            r_emitted    <= n_emitted;
            r_out_len    <= n_out_len;
            r_tree_bytes <= n_tree_bytes;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_hold_sym  <= n_hold_sym;
        r_hold_done <= n_hold_done;
        r_out_sym   <= n_out_sym;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
    end

    always_comb begin
        unique case (w_reg)
            REG_OUTPUT_LENGTH: prdata = {{(APB_DW - CNT_W){1'b0}}, r_out_len};
            REG_TREE_BYTES:    prdata = {{(APB_DW - TREE_W){1'b0}}, r_tree_bytes};
        endcase
    end

    assign pready        = 1'b1;
    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_out_valid;
    assign o_symbol      = r_out_sym;
    assign o_run_last    = r_out_last;
    assign o_stream_done = r_out_done;

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_valid)
        else $error("symbol left in hold at end of byte");

    a_hold_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_payload)
        else $error("symbol held during a header byte");

    a_emit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_adv) |=> r_hold_valid && r_emitted != '0)
        else $error("emitted symbol not captured");

endmodule

// ===== design/htd_tree_build.sv =====
module htd_tree_build import htd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_rd,
    input  logic     i_step,
    input  logic     i_bit,
    output t_node_wr o_node_wr,
    output logic     o_depth_nz
);

    logic [IDX_W-1:0]    r_stack [MAX_LEAVES];
    logic [IDX_W-1:0]    r_st_q;
    logic [IDX_W-1:0]    r_top;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [USED_W-1:0]   r_used, n_used;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [DEPTH_W-1:0]  w_dm2;
    logic [STACK_AW-1:0] w_st_wa;
    logic [IDX_W-1:0]    w_st_wd;
    logic                w_st_we;
    logic                w_room_node;
    logic                w_room_leaf;
    t_node_wr            w_wr;

    // second entry from the top; the top itself lives in r_top
    assign w_dm2       = r_depth - DEPTH_W'(2);
    assign w_room_node = r_used < USED_W'(NODE_CAP);
    assign w_room_leaf = (r_depth < DEPTH_W'(MAX_LEAVES)) && w_room_node;

    always_comb begin
        n_depth = r_depth;
        n_used  = r_used;
        n_pend  = r_pend;
        n_sym   = r_sym;
        w_wr    = '0;
        w_st_we = 1'b0;
        w_st_wa = r_depth[STACK_AW-1:0];
        w_st_wd = r_used[IDX_W-1:0];
        if (i_step && r_pend != PEND_DONE) begin
            if (r_pend != PEND_TAG) begin
                n_sym  = {r_sym[SYM_W-2:0], i_bit};
                n_pend = r_pend - PEND_LAST;
                if (r_pend == PEND_LAST && w_room_leaf) begin
                    w_wr.en        = 1'b1;
                    w_wr.addr      = r_used[IDX_W-1:0];
                    w_wr.data.leaf = 1'b1;
                    w_wr.data.sym  = n_sym;
                    w_st_we        = 1'b1;
                    n_depth        = r_depth + DEPTH_W'(1);
                    n_used         = r_used + USED_W'(1);
                end
            end else if (i_bit) begin
                n_pend = PEND_FULL;
            end else if (r_depth == DEPTH_W'(1)) begin
                n_pend = PEND_DONE;
            end else if (r_depth != '0 && w_room_node) begin
                // pop right (top) and left, push parent over them
                w_wr.en         = 1'b1;
                w_wr.addr       = r_used[IDX_W-1:0];
                w_wr.data.left  = r_st_q;
                w_wr.data.right = r_top;
                w_st_we         = 1'b1;
                w_st_wa         = w_dm2[STACK_AW-1:0];
                n_depth         = r_depth - DEPTH_W'(1);
                n_used          = r_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_used  <= '0;
            r_pend  <= PEND_TAG;
            r_sym   <= '0;
        end else begin
            r_depth <= n_depth;
            r_used  <= n_used;
            r_pend  <= n_pend;
            r_sym   <= n_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_stack[w_st_wa] <= w_st_wd;
        end
        if (i_rd) begin
            r_st_q <= r_stack[w_dm2[STACK_AW-1:0]];
        end
        if (w_wr.en) begin
            r_top <= w_wr.addr;
        end
    end

    assign o_node_wr  = w_wr;
    assign o_depth_nz = r_depth != '0;

    a_used_covers_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth != '0 |-> r_used >= USED_W'(r_depth))
        else $error("node count below stack depth");

    a_done_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == PEND_DONE |-> r_depth == DEPTH_W'(1))
        else $error("tree closed with other than one node on stack");

endmodule

// ===== design/htd_tree_walk.sv =====
module htd_tree_walk import htd_pkg::*; (
    input  logic             i_clk,
    input  t_node_wr         i_node_wr,
    input  logic             i_rd,
    input  logic             i_bit,
    input  logic             i_commit,
    output logic             o_hit,
    output logic [SYM_W-1:0] o_hit_sym
);

    t_node            r_mem [NODE_DEPTH];
    t_node            r_rd_q;
    t_node            r_walk;
    t_node            r_root;
    logic [IDX_W-1:0] w_child;

    // walk and root are kept as node contents, so each bit needs one read
    assign w_child = i_bit ? r_walk.right : r_walk.left;

    always_ff @(posedge i_clk) begin
        if (i_node_wr.en) begin
            r_mem[i_node_wr.addr] <= i_node_wr.data;
        end
        if (i_rd) begin
            r_rd_q <= r_mem[w_child];
        end
    end

    // every node write during the header is a push, so it is the new root
    always_ff @(posedge i_clk) begin
        if (i_node_wr.en) begin
            r_walk <= i_node_wr.data;
            r_root <= i_node_wr.data;
        end else if (i_commit) begin
            r_walk <= o_hit ? r_root : r_rd_q;
        end
    end

    assign o_hit     = r_walk.leaf || r_rd_q.leaf;
    assign o_hit_sym = r_walk.leaf ? r_walk.sym : r_rd_q.sym;

endmodule

// ===== verif/tb_huffman_tree_rebuild_and_decode_core.sv =====
`timescale 1ns / 1ps

module tb_huffman_tree_rebuild_and_decode_core import htd_pkg::*; ();

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    // long enough for a header byte, or a payload byte plus the held output beat
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int ROUNDS          = 8;
    localparam int PAYLOAD_PER_RND = 8;

    localparam logic [APB_DW-1:0] OUT_LEN_MAX  = 32'h7FFF_FFFF;
    localparam logic [SYM_W-1:0]  HASH_SYM     = 8'h23;   // '#'

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             run_last;
        logic             stream_done;
    } t_symbol_beat;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of tree rebuild / decode state. take_byte()
    // runs one accepted byte through it and queues the symbol beats it
    // should produce; check_symbol() pops the oldest one and compares.
    // ------------------------------------------------------------------
    class symbol_scoreboard;
        t_node                  node_tab [NODE_DEPTH];
        logic [IDX_W-1:0]       build_stk [MAX_LEAVES];
        int unsigned            stk_depth;
        int unsigned            node_count;
        logic [SYM_W-1:0]       sym_shift;
        logic [PEND_W-1:0]      sym_pending;
        int unsigned            hdr_seen;
        logic [IDX_W-1:0]       walk_idx;
        int unsigned            sym_count;
        int unsigned            out_len;
        int unsigned            tree_len;
        t_symbol_beat           pending_symbols [$];
        int                     errors;

        function new();
            stk_depth   = 0;
            node_count  = 0;
            sym_shift   = '0;
            sym_pending = PEND_TAG;
            hdr_seen    = 0;
            walk_idx    = '0;
            sym_count   = 0;
            out_len     = 0;
            tree_len    = 1;
            errors      = 0;
        endfunction

        function void write_reg(t_reg r, logic [APB_DW-1:0] v);
            case (r)
                REG_OUTPUT_LENGTH: out_len  = v[CNT_W-1:0];
                REG_TREE_BYTES:    tree_len = v[TREE_W-1:0];
                default: ;
            endcase
        endfunction

        // new node goes on top of the build stack; walk follows the top
        function void push_node(t_node n);
            node_tab[node_count] = n;
            build_stk[stk_depth] = node_count[IDX_W-1:0];
            stk_depth++;
            node_count++;
            walk_idx = build_stk[stk_depth-1];
        endfunction

        function void rebuild_bit(logic b);
            t_node            parent;
            logic [IDX_W-1:0] l_idx;
            logic [IDX_W-1:0] r_idx;
            if (sym_pending == PEND_DONE) return;
            if (sym_pending != PEND_TAG) begin
                sym_shift   = {sym_shift[SYM_W-2:0], b};
                sym_pending = sym_pending - 1'b1;
                // leaf dropped when stack or node table is full
                if (sym_pending == PEND_TAG && stk_depth < MAX_LEAVES &&
                    node_count < NODE_CAP) begin
                    push_node('{leaf: 1'b1, sym: sym_shift, default: '0});
                end
                return;
            end
            if (b) begin
                sym_pending = PEND_FULL;
                return;
            end
            if (stk_depth == 0) return;          // pop on empty: ignored
            if (stk_depth == 1) begin            // tree closed, rest is padding
                sym_pending = PEND_DONE;
                return;
            end
            if (node_count >= NODE_CAP) return;
            r_idx  = build_stk[stk_depth-1];
            l_idx  = build_stk[stk_depth-2];
            parent = '{leaf: 1'b0, sym: '0, left: l_idx, right: r_idx};
            node_tab[node_count]   = parent;
            build_stk[stk_depth-2] = node_count[IDX_W-1:0];
            stk_depth--;
            node_count++;
            walk_idx = build_stk[stk_depth-1];
        endfunction

        function void take_byte(logic [SYM_W-1:0] b);
            t_symbol_beat     beats [$];
            t_symbol_beat     nb;
            logic [IDX_W-1:0] root;
            logic [IDX_W-1:0] hit;
            if (hdr_seen < tree_len) begin
                hdr_seen++;
                for (int i = SYM_W - 1; i >= 0; i--) rebuild_bit(b[i]);
                return;
            end
            if (stk_depth == 0) return;          // no tree yet
            for (int i = SYM_W - 1; i >= 0; i--) begin
                root = build_stk[stk_depth-1];
                if (sym_count >= out_len) break;
                if (node_tab[walk_idx].leaf) begin
                    hit = walk_idx;              // single-leaf root
                end else begin
                    walk_idx = b[i] ? node_tab[walk_idx].right : node_tab[walk_idx].left;
                    if (!node_tab[walk_idx].leaf) continue;
                    hit = walk_idx;
                end
                walk_idx = root;
                sym_count++;
                nb.symbol      = node_tab[hit].sym;
                nb.run_last    = 1'b0;
                nb.stream_done = (sym_count == out_len);
                beats.push_back(nb);
            end
            if (beats.size() > 0) beats[beats.size()-1].run_last = 1'b1;
            foreach (beats[k]) pending_symbols.push_back(beats[k]);
        endfunction

        function void check_symbol(logic [SYM_W-1:0] sym, logic last, logic done);
            t_symbol_beat exp_beat;
            if (pending_symbols.size() == 0) begin
                $error("unexpected symbol beat: symbol %02h run_last %0b stream_done %0b",
                       sym, last, done);
                errors++;
                return;
            end
            exp_beat = pending_symbols.pop_front();
            if (sym !== exp_beat.symbol) begin
                $error("symbol: expected %02h, actual %02h", exp_beat.symbol, sym);
                errors++;
            end
            if (last !== exp_beat.run_last) begin
                $error("run_last: expected %0b, actual %0b", exp_beat.run_last, last);
                errors++;
            end
            if (done !== exp_beat.stream_done) begin
                $error("stream_done: expected %0b, actual %0b", exp_beat.stream_done, done);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [SYM_W-1:0]  i_stream_byte;
    logic              o_valid;
    logic              i_stall;
    logic [SYM_W-1:0]  o_symbol;
    logic              o_run_last;
    logic              o_stream_done;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    huffman_tree_rebuild_and_decode_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stream_byte (i_stream_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_symbol      (o_symbol),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    symbol_scoreboard sb = new();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // knobs shared by the driver processes
    int idle_pct  = 0;     // sender gap chance per cycle
    int stall_pct = 0;     // receiver stall chance per cycle
    int hold_left = 0;     // long receiver hold-off, counted down below

    logic [SYM_W-1:0] stream_q [$];   // bytes waiting to be sent
    bit               hdr_bits [$];   // serialized tree bits, MSB first
    int               carry_bits;     // symbol bits owed by a leaf split over a round

    // receiver: hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // output monitor: a beat moves when valid is high and stall is low
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_symbol(o_symbol, o_run_last, o_stream_done);
    end

    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // APB write: setup cycle, access cycle, done on the pready edge
    task automatic cfg_write(input t_reg r, input logic [APB_DW-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({r, 2'b00});
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer every byte in stream_q; valid stays up across back-to-back beats
    task automatic send_stream();
        logic [SYM_W-1:0] b;
        while (stream_q.size() != 0) begin
            b = stream_q.pop_front();
            while ($urandom_range(0, 99) < idle_pct) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            @(negedge i_clk);
            i_valid       <= 1'b1;
            i_stream_byte <= b;
            do @(posedge i_clk); while (!(i_valid && !o_stall));
            sb.take_byte(b);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // all symbols back, then let a trailing header byte finish
    task automatic wait_quiet();
        while (sb.pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [SYM_W-1:0] pick_symbol();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return HASH_SYM;
            default: return SYM_W'($urandom);
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SYM_W'($urandom);
        endcase
    endfunction

    function automatic void add_leaf(logic [SYM_W-1:0] sym);
        hdr_bits.push_back(1'b1);
        for (int i = SYM_W - 1; i >= 0; i--) hdr_bits.push_back(sym[i]);
    endfunction

    function automatic void add_rand_bits(int n);
        repeat (n) hdr_bits.push_back(1'($urandom_range(0, 1)));
    endfunction

    // keep the tree open at a byte boundary: start a leaf and finish it
    // in the next header chunk (a 0 bit here would close the tree)
    function automatic void pad_open();
        int rem;
        rem = (8 - hdr_bits.size() % 8) % 8;
        if (rem > 0) begin
            hdr_bits.push_back(1'b1);
            add_rand_bits(rem - 1);
            carry_bits = 9 - rem;
        end else begin
            carry_bits = 0;
        end
    endfunction

    function automatic int pack_header();
        logic [SYM_W-1:0] b;
        int               n;
        n = 0;
        while (hdr_bits.size() >= SYM_W) begin
            for (int i = SYM_W - 1; i >= 0; i--) b[i] = hdr_bits.pop_front();
            stream_q.push_back(b);
            n++;
        end
        hdr_bits.delete();
        return n;
    endfunction

    // well-formed chunk: finish carried leaf, random post-order subtree,
    // join everything back to one root, then reopen
    task automatic grow_tree(input int n_leaves);
        int depth;
        int sub_depth;
        int left;
        int n;
        depth = sb.stk_depth;
        if (carry_bits > 0) begin
            add_rand_bits(carry_bits);
            depth++;
        end
        sub_depth = 0;
        left      = n_leaves;
        while (left > 0 || sub_depth > 1) begin
            if (left > 0 && (sub_depth < 2 || $urandom_range(0, 1))) begin
                add_leaf(pick_symbol());
                sub_depth++;
                left--;
            end else begin
                hdr_bits.push_back(1'b0);
                sub_depth--;
            end
        end
        repeat (depth) hdr_bits.push_back(1'b0);
        pad_open();
        n = pack_header();
        cfg_write(REG_TREE_BYTES, sb.hdr_seen + n);
        send_stream();
        wait_quiet();
    endtask

    task automatic send_payload(input int n);
        repeat (n) stream_q.push_back(pick_payload());
        send_stream();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int idle_tab  [4] = '{0, 50, 0, 10};
    int stall_tab [4] = '{0, 0, 50, 10};

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stream_byte = '0;
        i_stall       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        carry_bits    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // one header byte of pops on an empty stack, then payload with no tree
        cfg_write(REG_TREE_BYTES, 1);
        cfg_write(REG_OUTPUT_LENGTH, OUT_LEN_MAX);
        stream_q = '{8'h00, 8'h00, 8'hFF};
        send_stream();
        wait_quiet();

        // single '#' leaf; header ends mid-leaf so the tree stays open
        add_leaf(HASH_SYM);
        pad_open();
        cfg_write(REG_TREE_BYTES, sb.hdr_seen + pack_header());
        send_stream();
        wait_quiet();

        // zero length: payload ignored
        cfg_write(REG_OUTPUT_LENGTH, 0);
        stream_q = '{8'hA5};
        send_stream();
        wait_quiet();

        // single-leaf root: one '#' per bit; count hits 13 mid-byte, then ignored
        cfg_write(REG_OUTPUT_LENGTH, sb.sym_count + 13);
        stream_q = '{8'h00, 8'hFF, 8'h5A};
        send_stream();
        wait_quiet();

        cfg_write(REG_OUTPUT_LENGTH, OUT_LEN_MAX);
        stream_q = '{8'hFF};
        send_stream();
        wait_quiet();

        // --- random rounds: tree grows each round, idle mode rotates ---
        for (int r = 0; r < ROUNDS; r++) begin
            idle_pct  = idle_tab[r % 4];
            stall_pct = stall_tab[r % 4];
            grow_tree($urandom_range(2, 6));
            if (r % 2 == 1)
                cfg_write(REG_OUTPUT_LENGTH, sb.sym_count + $urandom_range(1, 40));
            else
                cfg_write(REG_OUTPUT_LENGTH, OUT_LEN_MAX);
            // header count already past zero: every byte is payload
            if (r == 6) cfg_write(REG_TREE_BYTES, 0);
            // long receiver hold-off while bytes keep coming
            if (r == 2) hold_left = HOLD_CYCLES;
            send_payload(PAYLOAD_PER_RND);
            wait_quiet();
        end

        if (sb.errors == 0 && sb.pending_symbols.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/htd_pkg.sv
design/htd_tree_build.sv
design/htd_tree_walk.sv
design/huffman_tree_rebuild_and_decode_core.sv
verif/tb_huffman_tree_rebuild_and_decode_core.sv
